// ----- sv/fed_pkg.sv -----
`timescale 1ns / 1ps

package fed_pkg;

    // Operand width; the payload structs are built on it.
    localparam int unsigned FED_DATA_W = 32;

    typedef logic [FED_DATA_W-1:0] fed_word_t;

    typedef enum logic [1:0] {
        FED_OP_FLOOR_QUO = 2'd0,
        FED_OP_FLOOR_MOD = 2'd1,
        FED_OP_EUCL_QUO  = 2'd2,
        FED_OP_EUCL_MOD  = 2'd3
    } fed_op_t;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [FED_DATA_W-1:0] dividend;
        logic signed [FED_DATA_W-1:0] divisor;
    } fed_in_t;

    typedef struct packed {
        logic signed [FED_DATA_W-1:0] quotient_or_remainder;
        logic                         divide_by_zero;
    } fed_out_t;

    // Item in flight through the cell row.
    typedef struct packed {
        fed_op_t   op;
        logic      sa;   // dividend negative
        logic      sb;   // divisor negative
        logic      dz;   // divisor zero
        fed_word_t mb;   // divisor magnitude
        fed_word_t rem;  // partial remainder
        fed_word_t quo;  // dividend bits shifting out, quotient bits shifting in
    } fed_work_t;

endpackage

// ----- sv/floored_euclidean_divider.sv -----
// Stages, from input accept to result valid:
// one sign/magnitude stage, one restoring cell per quotient bit, one correction stage.
// Throughput: one item per cycle; every stage holds its own item and stalls only
// when the stage after it is full and blocked.
// Reset: aresetn, synchronous, active low; clears all stage valid bits, payload is kept.
`timescale 1ns / 1ps

module floored_euclidean_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fed_pkg::fed_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fed_pkg::fed_out_t m_data
);
    import fed_pkg::*;

    // Links between stages: index 0 leaves the front stage, index FED_DATA_W
    // leaves the last cell and feeds the correction stage.
    fed_work_t link_data  [FED_DATA_W+1];
    logic      link_valid [FED_DATA_W+1];
    logic      link_ready [FED_DATA_W+1];

    // Front stage: take the operands apart into signs and magnitudes,
    // flag a zero divisor, and load the dividend magnitude into the shifter.
    fed_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // Row of identical cells. Each one shifts the next dividend bit into the
    // partial remainder, subtracts the divisor magnitude when it fits, and
    // shifts the resulting quotient bit in at the bottom. After the last cell
    // the shifter holds the unsigned quotient and the remainder register the
    // unsigned remainder.
    for (genvar gi = 0; gi < FED_DATA_W; gi++) begin : g_cell
        fed_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[gi]),
            .in_ready  (link_ready[gi]),
            .in_data   (link_data[gi]),
            .out_valid (link_valid[gi+1]),
            .out_ready (link_ready[gi+1]),
            .out_data  (link_data[gi+1])
        );
    end

    // Correction stage: restore the signs, apply the one-step floored or
    // Euclidean adjustment when the remainder is nonzero, and force a zero
    // result with the error flag for a zero divisor. Its output register
    // holds the result until it is taken; the row behind it moves up into empty stages.
    fed_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[FED_DATA_W]),
        .in_ready  (link_ready[FED_DATA_W]),
        .in_data   (link_data[FED_DATA_W]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- sv/fed_pre.sv -----
`timescale 1ns / 1ps

module fed_pre (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fed_pkg::fed_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fed_pkg::fed_work_t out_data
);
    import fed_pkg::*;

    logic      valid_reg;
    fed_work_t work_reg;
    fed_work_t work_next;
    fed_word_t a_raw;
    fed_word_t b_raw;

    assign a_raw = fed_word_t'(in_data.dividend);
    assign b_raw = fed_word_t'(in_data.divisor);

    // Split operands into sign and magnitude; seed the row with a clear remainder.
    always_comb begin
        work_next.op  = fed_op_t'(in_data.opcode);
        work_next.sa  = a_raw[FED_DATA_W-1];
        work_next.sb  = b_raw[FED_DATA_W-1];
        work_next.dz  = (b_raw == '0);
        work_next.mb  = b_raw[FED_DATA_W-1] ? (~b_raw + fed_word_t'(1)) : b_raw;
        work_next.rem = '0;
        work_next.quo = a_raw[FED_DATA_W-1] ? (~a_raw + fed_word_t'(1)) : a_raw;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

// ----- sv/fed_cell.sv -----
`timescale 1ns / 1ps

module fed_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fed_pkg::fed_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fed_pkg::fed_work_t out_data
);
    import fed_pkg::*;

    logic                valid_reg;
    fed_work_t           work_reg;
    fed_work_t           work_next;
    logic [FED_DATA_W:0] shifted;
    logic [FED_DATA_W:0] trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {in_data.rem, in_data.quo[FED_DATA_W-1]};
    assign trial   = shifted - {1'b0, in_data.mb};

    always_comb begin
        work_next = in_data;
        if (!trial[FED_DATA_W]) begin
            work_next.rem = trial[FED_DATA_W-1:0];
        end else begin
            work_next.rem = shifted[FED_DATA_W-1:0];
        end
        work_next.quo = {in_data.quo[FED_DATA_W-2:0], !trial[FED_DATA_W]};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

// ----- sv/fed_post.sv -----
`timescale 1ns / 1ps

module fed_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fed_pkg::fed_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fed_pkg::fed_out_t  out_data
);
    import fed_pkg::*;

    logic      valid_reg;
    fed_out_t  data_reg;
    fed_out_t  data_next;
    fed_word_t mq;
    fed_word_t mr;
    logic      nz;
    logic      diff;
    fed_word_t res;

    assign mq   = in_data.quo;
    assign mr   = in_data.rem;
    assign nz   = (mr != '0);
    assign diff = in_data.sa ^ in_data.sb;

    // Each correction reduces to one add on the magnitudes:
    // -mq-1 is ~mq, and r+b or r+|b| is a difference of magnitudes.
    always_comb begin
        case (in_data.op)
            FED_OP_FLOOR_QUO: begin
                if (!diff) begin
                    res = mq;
                end else if (nz) begin
                    res = ~mq;
                end else begin
                    res = ~mq + fed_word_t'(1);
                end
            end
            FED_OP_FLOOR_MOD: begin
                if (nz && diff) begin
                    res = in_data.sa ? (in_data.mb - mr) : (mr - in_data.mb);
                end else begin
                    res = in_data.sa ? (~mr + fed_word_t'(1)) : mr;
                end
            end
            FED_OP_EUCL_QUO: begin
                if (nz && in_data.sa) begin
                    res = in_data.sb ? (mq + fed_word_t'(1)) : ~mq;
                end else begin
                    res = diff ? (~mq + fed_word_t'(1)) : mq;
                end
            end
            FED_OP_EUCL_MOD: begin
                if (nz && in_data.sa) begin
                    res = in_data.mb - mr;
                end else begin
                    res = mr;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_comb begin
        if (in_data.dz) begin
            data_next.quotient_or_remainder = '0;
            data_next.divide_by_zero        = 1'b1;
        end else begin
            data_next.quotient_or_remainder = res;
            data_next.divide_by_zero        = 1'b0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
